// ===== hw/rtl/edd_pkg.sv =====
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types and constants of the RGB565 error-diffusion ditherer.
// ----------------------------------------------------------------------------
package edd_pkg;

   // register indexes of the configuration port
   localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

   // transaction modes
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // color indexes
   localparam logic [2:0] COL_BLACK  = 3'd0;
   localparam logic [2:0] COL_BLUE   = 3'd1;
   localparam logic [2:0] COL_GREEN  = 3'd2;
   localparam logic [2:0] COL_RED    = 3'd3;
   localparam logic [2:0] COL_YELLOW = 3'd4;
   localparam logic [2:0] COL_WHITE  = 3'd5;

   // palette as RGB565
   function automatic logic [15:0] palette(input logic [2:0] idx);
      logic [15:0] p;
      case (idx)
         COL_BLACK:  p = 16'h0000;
         COL_BLUE:   p = 16'h001F;
         COL_GREEN:  p = 16'h07E0;
         COL_RED:    p = 16'hF800;
         COL_YELLOW: p = 16'hFFE0;
         COL_WHITE:  p = 16'hFFFF;
         default:    p = 16'h0000;
      endcase
      return p;
   endfunction

   // nearest palette color; ties broken by parity of x+y
   function automatic logic [2:0] choose_color(input logic [15:0] px, input logic odd);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      logic [2:0] c;
      r = px[15:11];
      g = px[10:5];
      b = px[4:0];
      if (r < 5'd16) begin
         if (g < 6'd32) c = (b < 5'd16) ? COL_BLACK : COL_BLUE;
         else if (b < 5'd16) c = COL_GREEN;
         else if (g[5:1] > b) c = COL_GREEN;
         else if (g[5:1] == b) c = odd ? COL_BLUE : COL_GREEN;
         else c = COL_BLUE;
      end else if (g < 6'd32) begin
         if (b < 5'd16) c = COL_RED;
         else if (r > b) c = COL_RED;
         else if (r == b) c = odd ? COL_BLUE : COL_RED;
         else c = COL_BLUE;
      end else begin
         c = (b < 5'd16) ? COL_YELLOW : COL_WHITE;
      end
      return c;
   endfunction

   // error times weight over 16, truncated toward zero
   function automatic logic signed [6:0] share(input logic signed [6:0] e,
                                               input logic [2:0] q);
      logic signed [10:0] p;
      logic signed [10:0] a;
      p = e * $signed({1'b0, q});
      a = (p < 0) ? -p : p;
      a = a >>> 4;
      return (p < 0) ? -a[6:0] : a[6:0];
   endfunction

   // control passed from sequencer to the update unit
   typedef struct packed {
      logic              start;
      logic [2:0]        weight;
      logic signed [6:0] er;
      logic signed [6:0] eg;
      logic signed [6:0] eb;
   } upd_ctl_type;

endpackage

// ===== hw/rtl/error_diffusion_dither_rgb565.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_dither_rgb565
// Floyd-Steinberg ditherer of RGB565 raster pixels to a six-color palette.
// ----------------------------------------------------------------------------
// Pixels wait in a line store of MAX_WIDTH+2 entries; a result leaves when
// the pixel width+1 places later arrives, and flush transactions drain the
// rest. A transaction that finalizes a pixel steps through a head read,
// quantization, four neighbour slots and the output stage, and requests
// are stalled until it is done; a neighbour is skipped, updated, or, if it
// overflows, also rescaled by the bit-serial divider. The result register
// holds one result while the next transaction is accepted; the output stage
// waits only when a second result is ready before the first has been taken.
// The line store is not cleared after reset.
module error_diffusion_dither_rgb565 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pixel_out,
   output logic [2:0]  rsp_color_index,
   output logic        rsp_last_of_frame,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int RING  = MAX_WIDTH + 2;
   localparam int AW    = $clog2(RING);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int NW    = $clog2(RING + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RHEAD = 3'd1;
   localparam logic [2:0] ST_QUANT = 3'd2;
   localparam logic [2:0] ST_NRD   = 3'd3;
   localparam logic [2:0] ST_NWAIT = 3'd4;
   localparam logic [2:0] ST_NUPD  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [10:0]   fw_ff, fw_in;
   logic [12:0]   fh_ff, fh_in;
   logic [AW-1:0] head_ff, head_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [CW:0]   acol_ff, acol_in, ecol_ff, ecol_in;
   logic [RW:0]   arow_ff, arow_in, erow_ff, erow_in;
   logic [1:0]    nb_ff, nb_in;
   logic [AW-1:0] nslot_ff, nslot_in;
   logic signed [6:0] er_ff, er_in, eg_ff, eg_in, eb_ff, eb_in;
   logic [2:0]    idx_ff, idx_in;
   logic          last_ff, last_in;
   logic          rv_ff, rv_in;
   logic [15:0]   rpx_ff, rpx_in;
   logic [2:0]    ridx_ff, ridx_in;
   logic          rlast_ff, rlast_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;
   edd_pkg::upd_ctl_type ctl;
   logic          upd_done;
   logic [15:0]   upd_res;

   logic [CW:0]   w;
   logic [RW:0]   h;
   logic          acc;
   logic          has_r, has_b;
   logic [AW:0]   koff;
   logic          nvalid;
   logic [AW:0]   sum;
   logic [15:0]   q;
   logic [2:0]    cidx;

   // effective frame size
   always_comb begin
      w = (fw_ff == 11'd0) ? (CW+1)'(1) :
          ({21'd0, fw_ff} > 32'(MAX_WIDTH)) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(fw_ff);
      h = (fh_ff == 13'd0) ? (RW+1)'(1) :
          ({19'd0, fh_ff} > 32'(MAX_HEIGHT)) ? (RW+1)'(MAX_HEIGHT) : (RW+1)'(fh_ff);
   end

   assign has_r = (ecol_ff + (CW+1)'(1)) < w;
   assign has_b = (erow_ff + (RW+1)'(1)) < h;
   assign acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // neighbour offset and presence for each of the four shares
   always_comb begin
      koff = '0;
      nvalid = 1'b0;
      ctl.start = (state_ff == ST_NWAIT);
      ctl.er = er_ff;
      ctl.eg = eg_ff;
      ctl.eb = eb_ff;
      ctl.weight = 3'd7;
      case (nb_ff)
         2'd0: begin koff = (AW+1)'(1); nvalid = has_r; ctl.weight = 3'd7; end
         2'd1: begin koff = (AW+1)'(w) - (AW+1)'(1);
                     nvalid = has_b && (ecol_ff != '0); ctl.weight = 3'd3; end
         2'd2: begin koff = (AW+1)'(w); nvalid = has_b; ctl.weight = 3'd5; end
         2'd3: begin koff = (AW+1)'(w) + (AW+1)'(1);
                     nvalid = has_b && has_r; ctl.weight = 3'd1; end
         default: ;
      endcase
      nvalid = nvalid && (koff < (AW+1)'(cnt_ff));
      sum = (AW+1)'(head_ff) + koff;
      if (sum >= (AW+1)'(RING)) sum = sum - (AW+1)'(RING);
   end

   assign cidx = edd_pkg::choose_color(rd_data, ecol_ff[0] ^ erow_ff[0]);
   assign q    = edd_pkg::palette(cidx);

   // sequencer
   always_comb begin
      logic [AW:0] tail;
      state_in = state_ff;
      fw_in = fw_ff; fh_in = fh_ff;
      head_in = head_ff; cnt_in = cnt_ff;
      acol_in = acol_ff; arow_in = arow_ff; ecol_in = ecol_ff; erow_in = erow_ff;
      nb_in = nb_ff; nslot_in = nslot_ff;
      er_in = er_ff; eg_in = eg_ff; eb_in = eb_ff;
      idx_in = idx_ff; last_in = last_ff;
      rv_in = rv_ff && rsp_stall;
      rpx_in = rpx_ff; ridx_in = ridx_ff; rlast_in = rlast_ff;
      wr_en = 1'b0; wr_addr = head_ff; wr_data = req_pixel_in;
      rd_addr = head_ff;
      tail = (AW+1)'(head_ff) + (AW+1)'(cnt_ff);
      if (tail >= (AW+1)'(RING)) tail = tail - (AW+1)'(RING);

      if (csr_write) begin
         if (csr_index == edd_pkg::REG_FRAME_WIDTH) fw_in = csr_data[10:0];
         else fh_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_mode == edd_pkg::MODE_PIXEL) begin
                  wr_en = 1'b1;
                  wr_addr = tail[AW-1:0];
                  cnt_in = cnt_ff + NW'(1);
                  if (acol_ff + (CW+1)'(1) >= w) begin
                     acol_in = '0;
                     arow_in = (arow_ff + (RW+1)'(1) >= h) ? '0 : arow_ff + (RW+1)'(1);
                  end else acol_in = acol_ff + (CW+1)'(1);
                  if ((NW+1)'(cnt_ff) + (NW+1)'(1) >= (NW+1)'(w) + (NW+1)'(2))
                     state_in = ST_RHEAD;
               end else if (cnt_ff != '0) begin
                  state_in = ST_RHEAD;
               end
            end
         end
         ST_RHEAD: state_in = ST_QUANT;
         // quantize the oldest pixel
         ST_QUANT: begin
            idx_in = cidx;
            er_in = 7'(signed'({2'b0, rd_data[15:11]})) - 7'(signed'({2'b0, q[15:11]}));
            eg_in = 7'(signed'({1'b0, rd_data[10:5]})) - 7'(signed'({1'b0, q[10:5]}));
            eb_in = 7'(signed'({2'b0, rd_data[4:0]})) - 7'(signed'({2'b0, q[4:0]}));
            last_in = !has_r && !has_b;
            nb_in = 2'd0;
            state_in = ST_NRD;
         end
         // issue read of next neighbour or finish
         ST_NRD: begin
            rd_addr = sum[AW-1:0];
            nslot_in = sum[AW-1:0];
            if (nvalid) state_in = ST_NWAIT;
            else if (nb_ff == 2'd3) state_in = ST_OUT;
            else nb_in = nb_ff + 2'd1;
         end
         ST_NWAIT: state_in = ST_NUPD;
         ST_NUPD: begin
            if (upd_done) begin
               wr_en = 1'b1;
               wr_addr = nslot_ff;
               wr_data = upd_res;
               if (nb_ff == 2'd3) state_in = ST_OUT;
               else begin
                  nb_in = nb_ff + 2'd1;
                  state_in = ST_NRD;
               end
            end
         end
         // deliver the transaction and retire the head once the register is free
         ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               rpx_in = edd_pkg::palette(idx_ff);
               ridx_in = idx_ff;
               rlast_in = last_ff;
               head_in = (head_ff == AW'(RING - 1)) ? '0 : head_ff + AW'(1);
               cnt_in = cnt_ff - NW'(1);
               if (ecol_ff + (CW+1)'(1) >= w) begin
                  ecol_in = '0;
                  erow_in = (erow_ff + (RW+1)'(1) >= h) ? '0 : erow_ff + (RW+1)'(1);
               end else ecol_in = ecol_ff + (CW+1)'(1);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fw_ff <= 11'd1024; fh_ff <= 13'd1;
         head_ff <= '0; cnt_ff <= '0;
         acol_ff <= '0; arow_ff <= '0; ecol_ff <= '0; erow_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fw_ff <= fw_in; fh_ff <= fh_in;
         head_ff <= head_in; cnt_ff <= cnt_in;
         acol_ff <= acol_in; arow_ff <= arow_in; ecol_ff <= ecol_in; erow_ff <= erow_in;
         rv_ff <= rv_in;
      end
      nb_ff <= nb_in; nslot_ff <= nslot_in;
      er_ff <= er_in; eg_ff <= eg_in; eb_ff <= eb_in;
      idx_ff <= idx_in; last_ff <= last_in;
      rpx_ff <= rpx_in; ridx_ff <= ridx_in; rlast_ff <= rlast_in;
   end

   // line store
   edd_ram #(.WIDTH(16), .DEPTH(RING)) u_line (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // neighbour update unit
   edd_update u_upd (
      .clock(clock), .reset(reset), .ctl(ctl), .px(rd_data),
      .done(upd_done), .result(upd_res)
   );

   assign rsp_valid         = rv_ff;
   assign rsp_pixel_out     = rpx_ff;
   assign rsp_color_index   = ridx_ff;
   assign rsp_last_of_frame = rlast_ff;

endmodule

// ===== hw/rtl/edd_ram.sv =====
// ----------------------------------------------------------------------------
// edd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module edd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1026
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/edd_update.sv =====
// ----------------------------------------------------------------------------
// edd_update
// Adds a weighted error share to a stored pixel, rescales overflow and
// clamps; multi-cycle rescale divides by the largest channel.
// ----------------------------------------------------------------------------
module edd_update (
   input  logic                clock,
   input  logic                reset,
   input  edd_pkg::upd_ctl_type ctl,
   input  logic [15:0]         px,
   output logic                done,
   output logic [15:0]         result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADD  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic signed [8:0]  r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic [2:0]         w_ff;
   logic signed [6:0]  er_ff, eg_ff, eb_ff;
   // divider: three quotients computed bit-serially
   logic [12:0]        nr_ff, nr_in, ng_ff, ng_in, nb_ff, nb_in;
   logic [7:0]         m_ff, m_in;
   logic [13:0]        rr_ff, rr_in, rg_ff, rg_in, rb_ff, rb_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [15:0]        res_ff, res_in;

   logic signed [8:0]  sr, sg, sb, gh, mx;
   logic [13:0]        tr, tg, tb;
   logic [8:0]         m2;

   function automatic logic [15:0] pack(input logic signed [8:0] r,
                                        input logic signed [8:0] g,
                                        input logic signed [8:0] b);
      logic [4:0] cr, cb;
      logic [5:0] cg;
      cr = (r < 0) ? 5'd0 : (r > 31) ? 5'd31 : r[4:0];
      cg = (g < 0) ? 6'd0 : (g > 63) ? 6'd63 : g[5:0];
      cb = (b < 0) ? 5'd0 : (b > 31) ? 5'd31 : b[4:0];
      return {cr, cg, cb};
   endfunction

   always_comb begin
      state_in = state_ff;
      r_in = r_ff; g_in = g_ff; b_in = b_ff;
      nr_in = nr_ff; ng_in = ng_ff; nb_in = nb_ff;
      m_in = m_ff; rr_in = rr_ff; rg_in = rg_ff; rb_in = rb_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      res_in = res_ff;
      sr = r_ff + 9'(edd_pkg::share(er_ff, w_ff));
      sg = g_ff + 9'(edd_pkg::share(eg_ff, w_ff));
      sb = b_ff + 9'(edd_pkg::share(eb_ff, w_ff));
      gh = sg >>> 1;
      mx = sr;
      if (gh > mx) mx = gh;
      if (sb > mx) mx = sb;
      if (mx < 1) mx = 9'sd1;
      m2 = {m_ff, 1'b0};
      tr = {rr_ff[12:0], nr_ff[12]};
      tg = {rg_ff[12:0], ng_ff[12]};
      tb = {rb_ff[12:0], nb_ff[12]};
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               r_in = $signed({4'd0, px[15:11]});
               g_in = $signed({3'd0, px[10:5]});
               b_in = $signed({4'd0, px[4:0]});
               state_in = ST_ADD;
            end
         end
         // add share; overflow goes to the divider
         ST_ADD: begin
            if (sr > 31 || sg > 63 || sb > 31) begin
               // only positive channels can carry value after rescale
               nr_in = (sr < 0) ? 13'd0 : 13'(sr) * 13'd31;
               ng_in = (sg < 0) ? 13'd0 : 13'(sg) * 13'd63;
               nb_in = (sb < 0) ? 13'd0 : 13'(sb) * 13'd31;
               m_in = mx[7:0];
               rr_in = '0; rg_in = '0; rb_in = '0;
               cnt_in = 4'd13;
               state_in = ST_DIV;
            end else begin
               res_in = pack(sr, sg, sb);
               done_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // restoring division, one bit per cycle
         ST_DIV: begin
            nr_in = {nr_ff[11:0], 1'b0};
            ng_in = {ng_ff[11:0], 1'b0};
            nb_in = {nb_ff[11:0], 1'b0};
            if (tr >= {6'd0, m_ff}) begin rr_in = tr - {6'd0, m_ff}; nr_in[0] = 1'b1; end
            else rr_in = tr;
            if (tg >= {5'd0, m2}) begin rg_in = tg - {5'd0, m2}; ng_in[0] = 1'b1; end
            else rg_in = tg;
            if (tb >= {6'd0, m_ff}) begin rb_in = tb - {6'd0, m_ff}; nb_in[0] = 1'b1; end
            else rb_in = tb;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               res_in = pack($signed({1'b0, nr_in[7:0]}), $signed({1'b0, ng_in[7:0]}),
                             $signed({1'b0, nb_in[7:0]}));
               done_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      r_ff <= r_in; g_ff <= g_in; b_ff <= b_in;
      nr_ff <= nr_in; ng_ff <= ng_in; nb_ff <= nb_in;
      m_ff <= m_in; rr_ff <= rr_in; rg_ff <= rg_in; rb_ff <= rb_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      if (ctl.start) begin
         w_ff <= ctl.weight; er_ff <= ctl.er; eg_ff <= ctl.eg; eb_ff <= ctl.eb;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the RGB565 error-diffusion ditherer: a line-store
// predictor computes each expected palette color, and a checker compares
// every result transaction under random idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int LINE_MAX  = 1024;
   localparam int ROWS_MAX  = 4096;
   localparam int RING      = LINE_MAX + 2;
   localparam int SETTLE    = 120;
   localparam int CYCLE_CAP = 4000000;

   typedef struct {
      logic [15:0] pixel;
      logic [2:0]  color;
      logic        last;
   } dither_out_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [15:0] req_pixel_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_pixel_out;
   logic [2:0]  rsp_color_index;
   logic        rsp_last_of_frame;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [12:0] csr_data;

   // predictor state
   logic [15:0] line_store [RING];
   int          ring_head;
   int          waiting;
   int          out_col;
   int          out_row;
   int          width_reg;
   int          height_reg;
   dither_out_type expected_px [$];

   int          send_idle_pct;
   int          stall_pct;
   int          hold_off;
   int          mismatches;
   int          results_seen;
   int          items_sent;
   int          cycle_count;

   error_diffusion_dither_rgb565 i_dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic logic [15:0] color_565(input logic [2:0] c);
      case (c)
         edd_pkg::COL_BLUE:   return 16'h001F;
         edd_pkg::COL_GREEN:  return 16'h07E0;
         edd_pkg::COL_RED:    return 16'hF800;
         edd_pkg::COL_YELLOW: return 16'hFFE0;
         edd_pkg::COL_WHITE:  return 16'hFFFF;
         default:             return 16'h0000;
      endcase
   endfunction

   function automatic int active_width();
      if (width_reg < 1) return 1;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
   endfunction

   function automatic int active_height();
      if (height_reg < 1) return 1;
      if (height_reg > ROWS_MAX) return ROWS_MAX;
      return height_reg;
   endfunction

   function automatic logic [2:0] nearest_color(input int r, input int g, input int b,
                                                input bit odd);
      if (r < 16) begin
         if (g < 32) return (b < 16) ? edd_pkg::COL_BLACK : edd_pkg::COL_BLUE;
         if (b < 16) return edd_pkg::COL_GREEN;
         if (g / 2 > b) return edd_pkg::COL_GREEN;
         if (g / 2 == b) return odd ? edd_pkg::COL_BLUE : edd_pkg::COL_GREEN;
         return edd_pkg::COL_BLUE;
      end
      if (g < 32) begin
         if (b < 16) return edd_pkg::COL_RED;
         if (r > b) return edd_pkg::COL_RED;
         if (r == b) return odd ? edd_pkg::COL_BLUE : edd_pkg::COL_RED;
         return edd_pkg::COL_BLUE;
      end
      return (b < 16) ? edd_pkg::COL_YELLOW : edd_pkg::COL_WHITE;
   endfunction

   function automatic int clip(input int v, input int full);
      if (v < 0) return 0;
      if (v > full) return full;
      return v;
   endfunction

   // add one weighted error share to a pending neighbour
   task automatic diffuse(input int k, input int er, input int eg, input int eb,
                          input int wt);
      int          slot;
      int          r;
      int          g;
      int          b;
      int          m;
      int          gh;
      logic [15:0] px;
      if (k >= waiting) return;
      slot = (ring_head + k) % RING;
      px = line_store[slot];
      r = int'(px[15:11]) + er * wt / 16;
      g = int'(px[10:5]) + eg * wt / 16;
      b = int'(px[4:0]) + eb * wt / 16;
      if (r > 31 || g > 63 || b > 31) begin
         gh = (g >= 0) ? g / 2 : -((1 - g) / 2);
         m = r;
         if (gh > m) m = gh;
         if (b > m) m = b;
         if (m < 1) m = 1;
         r = r * 31 / m;
         g = g * 63 / (2 * m);
         b = b * 31 / m;
      end
      r = clip(r, 31);
      g = clip(g, 63);
      b = clip(b, 31);
      line_store[slot] = {r[4:0], g[5:0], b[4:0]};
   endtask

   // quantize the oldest pending pixel and spread its error
   task automatic emit_oldest();
      int          w;
      int          h;
      int          r;
      int          g;
      int          b;
      bit          right_ok;
      bit          below_ok;
      logic [15:0] px;
      logic [15:0] q;
      dither_out_type o;
      w = active_width();
      h = active_height();
      px = line_store[ring_head];
      r = px[15:11];
      g = px[10:5];
      b = px[4:0];
      o.color = nearest_color(r, g, b, (out_col + out_row) % 2 == 1);
      q = color_565(o.color);
      r = r - int'(q[15:11]);
      g = g - int'(q[10:5]);
      b = b - int'(q[4:0]);
      right_ok = out_col + 1 < w;
      below_ok = out_row + 1 < h;
      if (right_ok) diffuse(1, r, g, b, 7);
      if (below_ok) begin
         if (out_col >= 1) diffuse(w - 1, r, g, b, 3);
         diffuse(w, r, g, b, 5);
         if (right_ok) diffuse(w + 1, r, g, b, 1);
      end
      o.pixel = q;
      o.last = !right_ok && !below_ok;
      expected_px.push_back(o);
      ring_head = (ring_head + 1) % RING;
      waiting--;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
   endtask

   task automatic predict_transaction(input logic mode, input logic [15:0] px);
      if (mode == edd_pkg::MODE_PIXEL) begin
         line_store[(ring_head + waiting) % RING] = px;
         waiting++;
         if (waiting >= active_width() + 2) emit_oldest();
      end else if (waiting > 0) begin
         emit_oldest();
      end
   endtask

   // send one transaction, then maybe idle
   task automatic send_item(input logic mode, input logic [15:0] px);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_pixel_in <= px;
      do @(posedge clock); while (req_stall);
      predict_transaction(mode, px);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [0:0] idx, input int value);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[12:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == edd_pkg::REG_FRAME_WIDTH) width_reg = value & 32'h7FF;
      else height_reg = value & 32'h1FFF;
   endtask

   // wait for every expected result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_px.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_frame(input int w, input int h);
      drain();
      write_reg(edd_pkg::REG_FRAME_WIDTH, w);
      write_reg(edd_pkg::REG_FRAME_HEIGHT, h);
   endtask

   task automatic flush_all();
      int n;
      n = waiting + 1;
      repeat (n) send_item(edd_pkg::MODE_FLUSH, 16'($urandom));
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      dither_out_type o;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_px.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %h idx %0d", rsp_pixel_out, rsp_color_index);
            end else begin
               o = expected_px.pop_front();
               if (o.pixel !== rsp_pixel_out || o.color !== rsp_color_index ||
                   o.last !== rsp_last_of_frame) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                              o.pixel, o.color, o.last,
                              rsp_pixel_out, rsp_color_index, rsp_last_of_frame);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // palette extremes, ties, overflow and negative error
   task automatic test_directed();
      logic [15:0] pix [12];
      pix = '{16'h0000, 16'hFFFF, 16'h0000 | (6'd40 << 5) | 5'd20,
              16'h0000 | (6'd40 << 5) | 5'd20, (5'd20 << 11) | 5'd20,
              (5'd20 << 11) | 5'd20, 16'hF800, 16'h07E0, 16'h001F,
              16'h7BEF, 16'h8410, 16'hFFE0};
      set_frame(1, 2);
      foreach (pix[i]) send_item(edd_pkg::MODE_PIXEL, pix[i]);
      flush_all();
      set_frame(3, 3);
      foreach (pix[i]) send_item(edd_pkg::MODE_PIXEL, pix[i]);
      flush_all();
   endtask

   // register extremes, including zero and out-of-range values
   task automatic test_frame_limits();
      set_frame(0, 0);
      repeat (6) send_item(edd_pkg::MODE_PIXEL, 16'($urandom));
      flush_all();
      set_frame(2047, 8191);
      repeat (12) send_item(edd_pkg::MODE_PIXEL, 16'($urandom));
      flush_all();
      set_frame(1024, 4096);
      repeat (8) send_item(edd_pkg::MODE_PIXEL, 16'($urandom));
      flush_all();
   endtask

   // random frames, mostly whole with stray flushes
   task automatic test_random_frames(input int idle_pct, input int stall_p, input int items);
      int n;
      int w;
      int h;
      send_idle_pct = idle_pct;
      stall_pct = stall_p;
      n = 0;
      while (n < items) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         set_frame(w, h);
         repeat (w * h * $urandom_range(1, 2)) begin
            if ($urandom_range(19) == 0) send_item(edd_pkg::MODE_FLUSH, 16'($urandom));
            else send_item(edd_pkg::MODE_PIXEL, 16'($urandom));
            n++;
         end
         // now and then change width with pixels still pending
         if ($urandom_range(3) == 0) begin
            drain();
            write_reg(edd_pkg::REG_FRAME_WIDTH, $urandom_range(1, 12));
         end
         flush_all();
      end
   endtask

   // long receiver hold while the sender keeps offering, then a full pause
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      set_frame(4, 5);
      hold_off = 400;
      repeat (60) send_item(edd_pkg::MODE_PIXEL, 16'($urandom));
      drain();
      repeat (20) send_item(edd_pkg::MODE_PIXEL, 16'($urandom));
      flush_all();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = edd_pkg::MODE_PIXEL;
      req_pixel_in = '0;
      csr_write = 1'b0;
      csr_index = edd_pkg::REG_FRAME_WIDTH;
      csr_data = '0;
      rsp_stall = 1'b0;
      hold_off = 0;
      mismatches = 0;
      results_seen = 0;
      items_sent = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      ring_head = 0;
      waiting = 0;
      out_col = 0;
      out_row = 0;
      width_reg = 1024;
      height_reg = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_frame_limits();
      test_random_frames(0, 0, 200);
      test_random_frames(65, 0, 200);
      test_random_frames(0, 65, 200);
      test_random_frames(21, 21, 200);
      test_backpressure();
      drain();

      $display("covered %0d transactions and %0d results over palette ties, frame limits,",
               items_sent, results_seen);
      $display("width changes with pixels pending, idle and stall phases and a long hold-off");
      if (mismatches == 0 && expected_px.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== error_diffusion_dither_rgb565.f =====
hw/rtl/edd_pkg.sv
hw/rtl/edd_ram.sv
hw/rtl/edd_update.sv
hw/rtl/error_diffusion_dither_rgb565.sv
bench/tb.sv
